// ===== rtl/kccp_pkg.sv =====
// shared types and constants for the k-means color cluster pass
// no dependencies; used by the controller, datapath, top level and testbench
`default_nettype none

package kccp_pkg;

  // opcodes of an input request
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // result kinds
  localparam logic KIND_LABEL  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // color channels as walked by the divider
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // configuration register file
  localparam logic       REG_ACTIVE    = 1'b0;
  localparam logic [4:0] ACTIVE_RESET  = 5'd16;
  localparam logic [4:0] REPORT_LIMIT  = 5'd16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] center_select;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] cluster_index;
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
    logic       cluster_empty;
    logic       last_result;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       take;
    logic       load;
    logic       scan_v;
    logic       scan_first;
    logic [3:0] idx;
    logic       acc_rd;
    logic       acc_wr;
    logic       pix_out;
    logic       ep_rd;
    logic       ep_chk;
    logic       div_start;
    logic [1:0] chan;
    logic       div_take;
    logic       ep_wr;
    logic       ep_out;
    logic       ep_last;
    logic       acc_clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_busy;
    logic ep_nonempty;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/kccp_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module kccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kccp_div.sv =====
// radix-2 restoring divider: floor(sum * 256 / cnt), quotient known below 2^16
// no dependencies
`default_nettype none

module kccp_div #(
  parameter int CW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CW+7:0] sum,
  input  wire logic [CW-1:0] cnt,
  output logic               busy,
  output logic               done,
  output logic [15:0]        quot
);

  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] den_r;
  logic [15:0]   low_r;
  logic [15:0]   quot_r;
  logic [4:0]    step_r;
  logic          busy_r, done_r;
  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          qbit;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, low_r[15]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= sum[CW+7:8];
      low_r <= {sum[7:0], 8'h00};
      den_r <= cnt;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_r[14:0], 1'b0};
      quot_r <= {quot_r[14:0], qbit};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== rtl/kccp_datapath.sv =====
// datapath: center and accumulator rams, distance pipeline, divider, result register
// depends on kccp_pkg, kccp_ram, kccp_div
`default_nettype none

module kccp_datapath #(
  parameter int MAX_CLUSTERS    = 16,
  parameter int MAX_PASS_PIXELS = 1048576
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kccp_pkg::in_item_t in_data,
  input  wire kccp_pkg::cmd_t     cmd,
  output kccp_pkg::sts_t          sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output kccp_pkg::out_item_t     out_data
);

  localparam int IW = $clog2(MAX_CLUSTERS);
  localparam int CW = $clog2(MAX_PASS_PIXELS + 1);
  localparam int SW = CW + 8;
  localparam int AW = 3 * SW + CW;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PASS_PIXELS);

  kccp_pkg::in_item_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_r <= in_data;
    end
  end

  // center store
  logic              load_ok;
  logic              c_we, c_re;
  logic [IW-1:0]     c_waddr, c_raddr;
  logic [47:0]       c_wdata, c_rdata, cen_q;
  logic [MAX_CLUSTERS-1:0] cv_r;
  logic              cvs_r;
  logic [47:0]       newc_r;

  assign load_ok = cmd.load && (32'(in_data.center_select) < MAX_CLUSTERS);
  assign c_we    = load_ok || cmd.ep_wr;
  assign c_waddr = cmd.ep_wr ? IW'(cmd.idx) : IW'(in_data.center_select);
  assign c_wdata = cmd.ep_wr ? newc_r :
                   {in_data.pixel_red, 8'h00, in_data.pixel_green, 8'h00,
                    in_data.pixel_blue, 8'h00};
  assign c_re    = cmd.scan_v || cmd.ep_rd;
  assign c_raddr = IW'(cmd.idx);

  kccp_ram #(.WIDTH(48), .DEPTH(MAX_CLUSTERS)) u_center_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (c_we) begin
      cv_r[c_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (c_re) begin
      cvs_r <= cv_r[c_raddr];
    end
  end

  // never-written center reads as zero
  assign cen_q = cvs_r ? c_rdata : 48'd0;

  // distance pipeline, one center per cycle
  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_first_r, s2_first_r, s3_first_r;
  logic [3:0]  s1_idx_r, s2_idx_r, s3_idx_r;
  logic [31:0] sq_r [3];
  logic [23:0] s2_col_r, s3_col_r;
  logic [33:0] dist_r;
  logic [33:0] best_d_r;
  logic [3:0]  best_idx_r;
  logic [23:0] best_col_r;
  logic [15:0] pch [3];
  logic [15:0] cch [3];
  logic [15:0] dch [3];

  always_comb begin
    pch[0] = {item_r.pixel_red, 8'h00};
    pch[1] = {item_r.pixel_green, 8'h00};
    pch[2] = {item_r.pixel_blue, 8'h00};
    cch[0] = cen_q[47:32];
    cch[1] = cen_q[31:16];
    cch[2] = cen_q[15:0];
    for (int k = 0; k < 3; k++) begin
      dch[k] = (pch[k] >= cch[k]) ? (pch[k] - cch[k]) : (cch[k] - pch[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.scan_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= cmd.idx;
    s1_first_r <= cmd.scan_first;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= dch[k] * dch[k];
    end
    s2_idx_r   <= s1_idx_r;
    s2_first_r <= s1_first_r;
    s2_col_r   <= {cen_q[47:40], cen_q[31:24], cen_q[15:8]};
    dist_r     <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
    s3_idx_r   <= s2_idx_r;
    s3_first_r <= s2_first_r;
    s3_col_r   <= s2_col_r;
    // strict less: lowest index wins ties
    if (s3_v_r && (s3_first_r || dist_r < best_d_r)) begin
      best_d_r   <= dist_r;
      best_idx_r <= s3_idx_r;
      best_col_r <= s3_col_r;
    end
  end

  // accumulator store: {sum red, sum green, sum blue, count}
  logic              a_we, a_re;
  logic [IW-1:0]     a_waddr, a_raddr;
  logic [AW-1:0]     a_wdata, a_rdata, acc_q;
  logic [MAX_CLUSTERS-1:0] av_r;
  logic              avs_r;
  logic [SW-1:0]     acc_sr, acc_sg, acc_sb;
  logic [CW-1:0]     acc_cnt;

  assign acc_q   = avs_r ? a_rdata : '0;
  assign acc_sr  = acc_q[AW-1 -: SW];
  assign acc_sg  = acc_q[AW-SW-1 -: SW];
  assign acc_sb  = acc_q[AW-2*SW-1 -: SW];
  assign acc_cnt = acc_q[CW-1:0];

  assign a_re    = cmd.acc_rd || cmd.ep_rd;
  assign a_raddr = cmd.acc_rd ? IW'(best_idx_r) : IW'(cmd.idx);
  assign a_we    = cmd.acc_wr && (acc_cnt < CNT_MAX);
  assign a_waddr = IW'(best_idx_r);
  assign a_wdata = {acc_sr + SW'(item_r.pixel_red),
                    acc_sg + SW'(item_r.pixel_green),
                    acc_sb + SW'(item_r.pixel_blue),
                    acc_cnt + CW'(1)};

  kccp_ram #(.WIDTH(AW), .DEPTH(MAX_CLUSTERS)) u_acc_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_clr) begin
      av_r <= '0;
    end else if (a_we) begin
      av_r[a_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_re) begin
      avs_r <= av_r[a_raddr];
    end
  end

  // end of pass: latch sums, divide channel by channel
  logic [SW-1:0] ep_sr_r, ep_sg_r, ep_sb_r, div_sum;
  logic [CW-1:0] ep_cnt_r;
  logic          ep_empty_r;
  logic          div_busy, div_done;
  logic [15:0]   div_quot;

  always_comb begin
    case (cmd.chan)
      kccp_pkg::CH_RED:   div_sum = ep_sr_r;
      kccp_pkg::CH_GREEN: div_sum = ep_sg_r;
      default:            div_sum = ep_sb_r;
    endcase
  end

  kccp_div #(.CW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .sum(div_sum),
    .cnt(ep_cnt_r), .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.ep_chk) begin
      ep_sr_r    <= acc_sr;
      ep_sg_r    <= acc_sg;
      ep_sb_r    <= acc_sb;
      ep_cnt_r   <= acc_cnt;
      ep_empty_r <= (acc_cnt == '0);
      newc_r     <= cen_q;
    end else if (cmd.div_take) begin
      case (cmd.chan)
        kccp_pkg::CH_RED:   newc_r[47:32] <= div_quot;
        kccp_pkg::CH_GREEN: newc_r[31:16] <= div_quot;
        default:            newc_r[15:0]  <= div_quot;
      endcase
    end
  end

  // result register
  logic                out_valid_r;
  kccp_pkg::out_item_t out_data_r;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pix_out || cmd.ep_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_out) begin
      out_data_r.result_kind   <= kccp_pkg::KIND_LABEL;
      out_data_r.cluster_index <= best_idx_r;
      out_data_r.color_red     <= best_col_r[23:16];
      out_data_r.color_green   <= best_col_r[15:8];
      out_data_r.color_blue    <= best_col_r[7:0];
      out_data_r.cluster_empty <= 1'b0;
      out_data_r.last_result   <= 1'b1;
    end else if (cmd.ep_out) begin
      out_data_r.result_kind   <= kccp_pkg::KIND_REPORT;
      out_data_r.cluster_index <= cmd.idx;
      out_data_r.color_red     <= newc_r[47:40];
      out_data_r.color_green   <= newc_r[31:24];
      out_data_r.color_blue    <= newc_r[15:8];
      out_data_r.cluster_empty <= ep_empty_r;
      out_data_r.last_result   <= cmd.ep_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.scan_busy   = s1_v_r || s2_v_r || s3_v_r;
  assign sts.ep_nonempty = (acc_cnt != '0);
  assign sts.div_done    = div_done;
  assign sts.out_free    = out_free;

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_acc_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_wr |-> $past(cmd.acc_rd))
    else $error("accumulator write without preceding read");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pix_out || cmd.ep_out) |-> out_free)
    else $error("result loaded over a waiting result");
  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_rd |-> !(s1_v_r || s2_v_r || s3_v_r))
    else $error("accumulator read before distance scan finished");

endmodule

`default_nettype wire

// ===== rtl/kccp_ctrl.sv =====
// controller state machine: sequences load, pixel and end-of-pass requests
// depends on kccp_pkg
`default_nettype none

module kccp_ctrl #(
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_opcode,
  input  wire logic [4:0]     active,
  input  wire kccp_pkg::sts_t sts,
  output logic                in_stall,
  output kccp_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_DRAIN   = 4'd2;
  localparam logic [3:0] S_ACC_RD  = 4'd3;
  localparam logic [3:0] S_ACC_WR  = 4'd4;
  localparam logic [3:0] S_PIX_OUT = 4'd5;
  localparam logic [3:0] S_EP_RD   = 4'd6;
  localparam logic [3:0] S_EP_CHK  = 4'd7;
  localparam logic [3:0] S_EP_DST  = 4'd8;
  localparam logic [3:0] S_EP_DIV  = 4'd9;
  localparam logic [3:0] S_EP_WR   = 4'd10;
  localparam logic [3:0] S_EP_OUT  = 4'd11;

  localparam logic [4:0] LIMIT = (MAX_CLUSTERS < 16) ? 5'(MAX_CLUSTERS)
                                                     : kccp_pkg::REPORT_LIMIT;

  logic [3:0] state_r, state_nxt;
  logic [4:0] i_r, i_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic [4:0] n_eff;
  logic       i_last;

  // zero acts as one, clamp to store size and report limit
  always_comb begin
    n_eff = (active == 5'd0) ? 5'd1 : active;
    if (n_eff > LIMIT) begin
      n_eff = LIMIT;
    end
  end

  assign i_last = (i_r + 5'd1 == n_eff);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    chan_nxt  = chan_r;
    cmd       = '0;
    cmd.idx   = i_r[3:0];
    cmd.chan  = chan_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          i_nxt    = 5'd0;
          case (in_opcode)
            kccp_pkg::OP_LOAD:  cmd.load  = 1'b1;
            kccp_pkg::OP_PIXEL: state_nxt = S_SCAN;
            kccp_pkg::OP_END:   state_nxt = S_EP_RD;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_v     = 1'b1;
        cmd.scan_first = (i_r == 5'd0);
        i_nxt          = i_r + 5'd1;
        if (i_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.scan_busy) begin
          state_nxt = S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_nxt  = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_nxt  = S_PIX_OUT;
      end
      S_PIX_OUT: begin
        if (sts.out_free) begin
          cmd.pix_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_EP_RD: begin
        cmd.ep_rd = 1'b1;
        state_nxt = S_EP_CHK;
      end
      S_EP_CHK: begin
        cmd.ep_chk = 1'b1;
        chan_nxt   = kccp_pkg::CH_RED;
        state_nxt  = sts.ep_nonempty ? S_EP_DST : S_EP_OUT;
      end
      S_EP_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_EP_DIV;
      end
      S_EP_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          if (chan_r == kccp_pkg::CH_BLUE) begin
            state_nxt = S_EP_WR;
          end else begin
            chan_nxt  = chan_r + 2'd1;
            state_nxt = S_EP_DST;
          end
        end
      end
      S_EP_WR: begin
        cmd.ep_wr = 1'b1;
        state_nxt = S_EP_OUT;
      end
      S_EP_OUT: begin
        cmd.ep_last = i_last;
        if (sts.out_free) begin
          cmd.ep_out = 1'b1;
          if (i_last) begin
            cmd.acc_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            i_nxt     = i_r + 5'd1;
            state_nxt = S_EP_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      chan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      chan_r  <= chan_nxt;
    end
  end

  a_clr_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |-> (cmd.ep_out && cmd.ep_last))
    else $error("accumulators cleared outside final report");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_v || cmd.ep_rd) |-> (i_r < n_eff))
    else $error("center index beyond active count");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_EP_DIV))
    else $error("divider start not followed by wait");

endmodule

`default_nettype wire

// ===== rtl/kmeans_color_cluster_pass.sv =====
// top level of the k-means color cluster pass: config register and glue
// depends on kccp_pkg, kccp_ctrl, kccp_datapath (and through it kccp_ram, kccp_div)
//
// usage
//   input channel (in_valid / in_stall / in_data): one request per handshake,
//     opcode load center, pixel or end of pass
//   result channel (out_valid / out_stall / out_data): pixel label per pixel,
//     one center report per active center at end of pass, last_result on the final one
//   apb port: register 0 at byte address 0 is active_clusters (5 bits, reset 16)
//   request sequence
//     load center: written to the center store as it is taken, no result
//     pixel: the distance pipeline reads one center per cycle over the active centers,
//       then a read-modify-write of the accumulators, then the label goes to the output
//       register once it is free; the next request is taken after that
//     end of pass: per active center the accumulators are read; an empty one is reported
//       as is, else one shared bit-serial divider produces each q8.8 channel in 16 steps
//   one request at a time: in_stall stays high until its last result is in the
//   output register; a stalled result holds there while the next request is taken
//   reset: centers read as zero, accumulators clear, no clearing sweep needed
`default_nettype none

module kmeans_color_cluster_pass #(
  parameter int MAX_CLUSTERS    = 16,
  parameter int MAX_PASS_PIXELS = 1048576
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire kccp_pkg::in_item_t  in_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output kccp_pkg::out_item_t      out_data,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  kccp_pkg::cmd_t cmd;
  kccp_pkg::sts_t sts;

  // active_clusters register, word address in paddr[2]
  logic [4:0] active_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == kccp_pkg::REG_ACTIVE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= kccp_pkg::ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_r <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == kccp_pkg::REG_ACTIVE) ? {27'd0, active_r} : 32'd0;

  // sequencing
  kccp_ctrl #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .active    (active_r),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // storage, arithmetic and result register
  kccp_datapath #(
    .MAX_CLUSTERS    (MAX_CLUSTERS),
    .MAX_PASS_PIXELS (MAX_PASS_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/kmeans_color_cluster_pass_tb.sv =====
// testbench for the k-means color cluster pass: random and directed requests,
// a cluster predictor in a small scoreboard class; depends on kccp_pkg and the rtl
`timescale 1ns / 100ps

module kmeans_color_cluster_pass_tb;

  class cluster_scoreboard;
    logic [15:0] ctr_r [16];
    logic [15:0] ctr_g [16];
    logic [15:0] ctr_b [16];
    logic [27:0] acc_r [16];
    logic [27:0] acc_g [16];
    logic [27:0] acc_b [16];
    logic [20:0] members [16];
    logic [4:0]  active_reg;
    kccp_pkg::out_item_t pending [$];
    int          errors;

    function void clear_sums();
      for (int i = 0; i < 16; i++) begin
        acc_r[i] = '0; acc_g[i] = '0; acc_b[i] = '0; members[i] = '0;
      end
    endfunction

    function void reset_state();
      for (int i = 0; i < 16; i++) begin
        ctr_r[i] = '0; ctr_g[i] = '0; ctr_b[i] = '0;
      end
      clear_sums();
      active_reg = kccp_pkg::ACTIVE_RESET;
      errors = 0;
      pending.delete();
    endfunction

    function int used_centers();
      int n;
      n = active_reg;
      if (n == 0) n = 1;
      if (n > 16) n = 16;
      return n;
    endfunction

    function longint sqd(logic [7:0] p, logic [15:0] c);
      longint d;
      d = longint'({p, 8'd0}) - longint'(c);
      return d * d;
    endfunction

    function kccp_pkg::out_item_t center_result(logic kind, int i, logic empty,
                                                logic last);
      kccp_pkg::out_item_t o;
      o.result_kind = kind;
      o.cluster_index = i[3:0];
      o.color_red = ctr_r[i][15:8];
      o.color_green = ctr_g[i][15:8];
      o.color_blue = ctr_b[i][15:8];
      o.cluster_empty = empty;
      o.last_result = last;
      return o;
    endfunction

    // predict the results of one accepted request
    function void note_request(kccp_pkg::in_item_t it);
      int n, best;
      longint d, best_d;
      n = used_centers();
      case (it.opcode)
        kccp_pkg::OP_LOAD: begin
          ctr_r[it.center_select] = {it.pixel_red, 8'd0};
          ctr_g[it.center_select] = {it.pixel_green, 8'd0};
          ctr_b[it.center_select] = {it.pixel_blue, 8'd0};
        end
        kccp_pkg::OP_PIXEL: begin
          best = 0;
          best_d = 0;
          for (int i = 0; i < n; i++) begin
            d = sqd(it.pixel_red, ctr_r[i]) + sqd(it.pixel_green, ctr_g[i]) +
                sqd(it.pixel_blue, ctr_b[i]);
            if (i == 0 || d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          if (members[best] < 21'd1048576) begin
            acc_r[best] += it.pixel_red;
            acc_g[best] += it.pixel_green;
            acc_b[best] += it.pixel_blue;
            members[best] += 1;
          end
          pending.push_back(center_result(kccp_pkg::KIND_LABEL, best, 1'b0, 1'b1));
        end
        kccp_pkg::OP_END: begin
          for (int i = 0; i < n; i++) begin
            if (members[i] != 0) begin
              ctr_r[i] = 16'(({36'd0, acc_r[i]} << 8) / members[i]);
              ctr_g[i] = 16'(({36'd0, acc_g[i]} << 8) / members[i]);
              ctr_b[i] = 16'(({36'd0, acc_b[i]} << 8) / members[i]);
            end
            pending.push_back(center_result(kccp_pkg::KIND_REPORT, i, members[i] == 0,
                                            i + 1 == n));
          end
          clear_sums();
        end
        default: ;
      endcase
    endfunction

    function void check_result(kccp_pkg::out_item_t got);
      kccp_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.result_kind != want.result_kind) begin
        $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind); errors++;
      end
      if (got.cluster_index != want.cluster_index) begin
        $error("cluster_index exp %0d got %0d", want.cluster_index, got.cluster_index);
        errors++;
      end
      if (got.color_red != want.color_red) begin
        $error("color_red exp %0d got %0d", want.color_red, got.color_red); errors++;
      end
      if (got.color_green != want.color_green) begin
        $error("color_green exp %0d got %0d", want.color_green, got.color_green); errors++;
      end
      if (got.color_blue != want.color_blue) begin
        $error("color_blue exp %0d got %0d", want.color_blue, got.color_blue); errors++;
      end
      if (got.cluster_empty != want.cluster_empty) begin
        $error("cluster_empty exp %0d got %0d", want.cluster_empty, got.cluster_empty);
        errors++;
      end
      if (got.last_result != want.last_result) begin
        $error("last_result exp %0d got %0d", want.last_result, got.last_result); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  kccp_pkg::in_item_t in_data;
  kccp_pkg::out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  cluster_scoreboard sb;
  int cycle_count;
  bit hold_long;   // request from the stimulus for a long receiver hold-off
  bit sink_random; // receiver stalls at random when set

  kmeans_color_cluster_pass dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: reports failure and stops if the run does not finish in time
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("kmeans_color_cluster_pass test failed");
        $finish;
      end
    end
  end

  // result side: accept and check, stall at random or for a long stretch
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        if (out_valid && !out_stall) sb.check_result(out_data);
        hold_long = 1'b0;
        out_stall <= 1'b0;
      end else if (sink_random && out_valid && !out_stall) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // apb write of active_clusters, only while the block is idle
  task automatic write_active(logic [4:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'd0; pwdata <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.active_reg = value;
  endtask

  // offer one request and hold it until accepted; valid drops only for an idle gap
  task automatic send_request(kccp_pkg::in_item_t it, bit idle_gaps);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // a load or ignored request may still be in flight
    repeat (80) @(posedge clk);
  endtask

  function automatic kccp_pkg::in_item_t make_req(logic [1:0] op, logic [3:0] sel,
                                                  logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
    kccp_pkg::in_item_t it;
    it.opcode = op; it.center_select = sel;
    it.pixel_red = r; it.pixel_green = g; it.pixel_blue = b;
    return it;
  endfunction

  function automatic kccp_pkg::in_item_t rand_pixel();
    return make_req(kccp_pkg::OP_PIXEL, 4'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
  endfunction

  initial begin
    logic [4:0] settings [6];
    sb = new();
    sb.reset_state();
    hold_long = 1'b0;
    sink_random = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: never-loaded centers tie at zero, so index 0 wins
    send_request(make_req(kccp_pkg::OP_PIXEL, 4'd0, 8'd0, 8'd0, 8'd0), 0);
    send_request(make_req(kccp_pkg::OP_PIXEL, 4'd15, 8'd255, 8'd255, 8'd255), 0);
    send_request(make_req(kccp_pkg::OP_LOAD, 4'd0, 8'd255, 8'd0, 8'd255), 0);
    send_request(make_req(kccp_pkg::OP_LOAD, 4'd15, 8'd0, 8'd255, 8'd0), 0);
    send_request(make_req(kccp_pkg::OP_LOAD, 4'd7, 8'd128, 8'd128, 8'd128), 0);
    send_request(make_req(kccp_pkg::OP_PIXEL, 4'd0, 8'd250, 8'd3, 8'd250), 0);
    send_request(make_req(kccp_pkg::OP_PIXEL, 4'd0, 8'd1, 8'd254, 8'd2), 0);
    send_request(make_req(kccp_pkg::OP_PIXEL, 4'd0, 8'd127, 8'd130, 8'd129), 0);
    send_request(make_req(kccp_pkg::OP_PIXEL, 4'd0, 8'd255, 8'd0, 8'd254), 0);
    // unused opcode is ignored
    send_request(make_req(2'd3, 4'd9, 8'd77, 8'd88, 8'd99), 0);
    send_request(make_req(kccp_pkg::OP_END, 4'd0, 8'd0, 8'd0, 8'd0), 0);
    // a pass with no members at all keeps every center
    send_request(make_req(kccp_pkg::OP_END, 4'd15, 8'd255, 8'd255, 8'd255), 0);
    drain();

    // zero acts as one center; wide values clamp to sixteen
    settings = '{5'd0, 5'd1, 5'd31, 5'd2, 5'd16, 5'd0};
    for (int s = 0; s < 6; s++) begin
      write_active(settings[s] == 5'd0 && s == 5 ? 5'($urandom_range(3, 15)) : settings[s]);
      sink_random = (s != 1);
      for (int k = 0; k < 4; k++)
        send_request(make_req(kccp_pkg::OP_LOAD, 4'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom)), s != 0);
      for (int k = 0; k < 14; k++) begin
        if (s == 3 && k == 2) hold_long = 1'b1;
        if ($urandom_range(0, 9) == 0)
          send_request(make_req(2'($urandom), 4'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom)), 1);
        else
          send_request(rand_pixel(), s != 0);
      end
      send_request(make_req(kccp_pkg::OP_END, 4'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom)), 1);
      // sender waits for every result before the next pass
      drain();
    end

    while (hold_long) @(posedge clk);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("kmeans_color_cluster_pass test passed");
    end else begin
      $display("kmeans_color_cluster_pass test failed");
    end
    $finish;
  end
endmodule
